>>> hdl/ssoc_pkg.sv
// shared types, constants and the gap table for the shell sort block
// no dependencies; imported by ssoc_mem and shell_sort_with_op_count
`default_nettype none

package ssoc_pkg;

  localparam int unsigned MaxItemsDef  = 64;
  localparam int unsigned DataWidthDef = 16;
  localparam int unsigned GapW         = 11;
  localparam int unsigned OpsW         = 16;
  localparam int unsigned LevelW       = 2;

  // set sizes above which the starting gap grows by one more step
  localparam int unsigned Thresh1 = 7;
  localparam int unsigned Thresh2 = 20;
  localparam int unsigned Thresh3 = 54;

  typedef enum logic {
    GAP_MODE_2K  = 1'b0,
    GAP_MODE_10K = 1'b1
  } gap_mode_e;

  typedef enum logic [3:0] {
    S_IDLE,
    S_GAP,
    S_RD_I,
    S_HOLD,
    S_CHK,
    S_CMP,
    S_PLACE,
    S_ORD,
    S_OLD,
    S_OWAIT
  } ssoc_state_e;

  // gap for a given series and level; level 0 is always gap 1
  function automatic logic [GapW-1:0] gap_of(gap_mode_e mode, logic [LevelW-1:0] level);
    logic [GapW-1:0] g;
    g = GapW'(1);
    case ({mode, level})
      {GAP_MODE_2K, 2'd0}:  g = GapW'(1);
      {GAP_MODE_2K, 2'd1}:  g = GapW'(3);
      {GAP_MODE_2K, 2'd2}:  g = GapW'(7);
      {GAP_MODE_2K, 2'd3}:  g = GapW'(15);
      {GAP_MODE_10K, 2'd0}: g = GapW'(1);
      {GAP_MODE_10K, 2'd1}: g = GapW'(11);
      {GAP_MODE_10K, 2'd2}: g = GapW'(111);
      {GAP_MODE_10K, 2'd3}: g = GapW'(1111);
      default:              g = GapW'(1);
    endcase
    return g;
  endfunction

endpackage

`default_nettype wire

>>> hdl/shell_sort_with_op_count.sv
// shell sort with comparison and move count: loads a set, sorts it in place, streams it out
// depends on ssoc_pkg and ssoc_mem (single-port-write, registered-read element store)
// loading: one item per cycle; the item marked last starts the sort
// sorting: one S_GAP step per gap level, then per gapped insertion S_RD_I, S_HOLD, S_CMP
//   and S_PLACE, with S_CMP and S_CHK repeated for each element shift; paced by the one
//   read port of the element store; worst case grows as n*n
// output: per result S_ORD, S_OLD, then S_OWAIT until taken; the next result waits for it
// reset: asynchronous, active low; empty set, counters zero, gap 1, mode 0; no store clearing
`default_nettype none

module shell_sort_with_op_count
  import ssoc_pkg::*;
#(
  parameter int unsigned MAX_ITEMS  = MaxItemsDef,
  parameter int unsigned DATA_WIDTH = DataWidthDef
) (
  input  wire logic                  clk_i,
  input  wire logic                  rst_ni,
  // input channel
  input  wire logic                  in_valid_i,
  output logic                       in_stall_o,
  input  wire logic [DATA_WIDTH-1:0] value_i,
  input  wire logic                  last_i,
  // output channel
  output logic                       out_valid_o,
  input  wire logic                  out_stall_i,
  output logic      [DATA_WIDTH-1:0] sorted_value_o,
  output logic                       last_out_o,
  output logic      [OpsW-1:0]       op_count_o,
  // configuration: gap factor mode
  input  wire logic                  cfg_valid_i,
  output logic                       cfg_ready_o,
  input  wire logic                  cfg_data_i
);

  localparam int unsigned AW = $clog2(MAX_ITEMS);
  localparam int unsigned CW = $clog2(MAX_ITEMS + 1);
  localparam logic [OpsW-1:0] OpsMax = {OpsW{1'b1}};

  // control state
  ssoc_state_e       state_q, state_d;
  logic [CW-1:0]     cnt_q, cnt_d;     // items held in the current set
  logic [CW-1:0]     n_q, n_d;         // size of the set being sorted
  logic [CW-1:0]     i_q, i_d;         // outer insertion index
  logic [AW-1:0]     j_q, j_d;         // hole position of the insertion
  logic [AW-1:0]     k_q, k_d;         // output index
  logic [LevelW-1:0] lvl_q, lvl_d;     // gap level, counts down to 0
  logic [GapW-1:0]   gap_q, gap_d;
  logic [OpsW-1:0]   cmp_q, cmp_d;
  logic [OpsW-1:0]   mov_q, mov_d;
  logic              mode_q;
  logic              out_valid_q, out_valid_d;

  // payload registers
  logic [DATA_WIDTH-1:0] held_q, held_d;
  logic [DATA_WIDTH-1:0] out_data_q, out_data_d;
  logic                  out_last_q, out_last_d;
  logic [OpsW-1:0]       out_ops_q, out_ops_d;

  // element store port
  logic                  we;
  logic [AW-1:0]         waddr;
  logic [DATA_WIDTH-1:0] wdata;
  logic [AW-1:0]         raddr;
  logic [DATA_WIDTH-1:0] rdata;

  // shared compare / subtract datapath
  logic [GapW-1:0]   gap_tab;
  logic [GapW-1:0]   j_ext, i_ext, n_ext;
  logic [GapW-1:0]   j_minus, i_minus;
  logic              j_ge_gap;
  logic              shift_needed;
  logic [OpsW-1:0]   cmp_inc, mov_inc;
  logic [OpsW:0]     ops_sum;
  logic [OpsW-1:0]   ops_total;
  logic              cnt_full;
  logic [CW-1:0]     cnt_after;
  logic [GapW-1:0]   n_new_ext;
  logic [LevelW-1:0] lvl_start;
  logic              in_xfer, out_xfer;

  ssoc_mem #(
    .DEPTH (MAX_ITEMS),
    .DW    (DATA_WIDTH),
    .AW    (AW)
  ) u_mem (
    .clk_i   (clk_i),
    .we_i    (we),
    .waddr_i (waddr),
    .wdata_i (wdata),
    .raddr_i (raddr),
    .rdata_o (rdata)
  );

  assign gap_tab  = gap_of(gap_mode_e'(mode_q), lvl_q);
  assign j_ext    = GapW'(j_q);
  assign i_ext    = GapW'(i_q);
  assign n_ext    = GapW'(n_q);
  assign j_minus  = j_ext - gap_q;
  assign i_minus  = i_ext - gap_q;
  assign j_ge_gap = (j_ext >= gap_q);
  // the neighbor one gap back is larger than the held value
  assign shift_needed = ($signed(rdata) > $signed(held_q));

  assign cmp_inc   = (cmp_q == OpsMax) ? cmp_q : cmp_q + OpsW'(1);
  assign mov_inc   = (mov_q == OpsMax) ? mov_q : mov_q + OpsW'(1);
  assign ops_sum   = {1'b0, cmp_q} + {1'b0, mov_q};
  assign ops_total = ops_sum[OpsW] ? OpsMax : ops_sum[OpsW-1:0];

  // a full store drops the item but a last marker still starts the sort
  assign cnt_full  = (cnt_q == CW'(MAX_ITEMS));
  assign cnt_after = cnt_full ? cnt_q : cnt_q + CW'(1);
  assign n_new_ext = GapW'(cnt_after);

  always_comb begin
    if (n_new_ext > GapW'(Thresh3)) begin
      lvl_start = LevelW'(3);
    end else if (n_new_ext > GapW'(Thresh2)) begin
      lvl_start = LevelW'(2);
    end else if (n_new_ext > GapW'(Thresh1)) begin
      lvl_start = LevelW'(1);
    end else begin
      lvl_start = LevelW'(0);
    end
  end

  assign in_xfer  = in_valid_i & ~in_stall_o;
  assign out_xfer = out_valid_q & ~out_stall_i;

  // sequencer: next state, store port and datapath register updates
  always_comb begin
    state_d     = state_q;
    cnt_d       = cnt_q;
    n_d         = n_q;
    i_d         = i_q;
    j_d         = j_q;
    k_d         = k_q;
    lvl_d       = lvl_q;
    gap_d       = gap_q;
    cmp_d       = cmp_q;
    mov_d       = mov_q;
    held_d      = held_q;
    out_valid_d = out_valid_q;
    out_data_d  = out_data_q;
    out_last_d  = out_last_q;
    out_ops_d   = out_ops_q;
    we          = 1'b0;
    waddr       = j_q;
    wdata       = held_q;
    raddr       = j_minus[AW-1:0];

    case (state_q)
      S_IDLE: begin
        if (in_xfer) begin
          if (!cnt_full) begin
            we    = 1'b1;
            waddr = cnt_q[AW-1:0];
            wdata = value_i;
          end
          cnt_d = cnt_after;
          if (last_i) begin
            // set closed: start the sort with fresh counters
            n_d     = cnt_after;
            cnt_d   = '0;
            lvl_d   = lvl_start;
            cmp_d   = '0;
            mov_d   = '0;
            state_d = S_GAP;
          end
        end
      end

      S_GAP: begin
        gap_d = gap_tab;
        if (gap_tab < n_ext) begin
          i_d     = gap_tab[CW-1:0];
          state_d = S_RD_I;
        end else if (lvl_q == '0) begin
          k_d     = '0;
          state_d = S_ORD;
        end else begin
          lvl_d   = lvl_q - LevelW'(1);
          state_d = S_GAP;
        end
      end

      S_RD_I: begin
        raddr   = i_q[AW-1:0];
        state_d = S_HOLD;
      end

      S_HOLD: begin
        // i is at least one gap, so the first neighbor always exists
        held_d  = rdata;
        cmp_d   = cmp_inc;
        j_d     = i_q[AW-1:0];
        raddr   = i_minus[AW-1:0];
        state_d = S_CMP;
      end

      S_CHK: begin
        if (j_ge_gap) begin
          raddr   = j_minus[AW-1:0];
          state_d = S_CMP;
        end else begin
          state_d = S_PLACE;
        end
      end

      S_CMP: begin
        if (shift_needed) begin
          cmp_d   = cmp_inc;
          mov_d   = mov_inc;
          we      = 1'b1;
          waddr   = j_q;
          wdata   = rdata;
          j_d     = j_minus[AW-1:0];
          state_d = S_CHK;
        end else begin
          state_d = S_PLACE;
        end
      end

      S_PLACE: begin
        we    = 1'b1;
        waddr = j_q;
        wdata = held_q;
        mov_d = mov_inc;
        i_d   = i_q + CW'(1);
        if ((i_q + CW'(1)) < n_q) begin
          state_d = S_RD_I;
        end else if (lvl_q == '0) begin
          k_d     = '0;
          state_d = S_ORD;
        end else begin
          lvl_d   = lvl_q - LevelW'(1);
          state_d = S_GAP;
        end
      end

      S_ORD: begin
        raddr   = k_q;
        state_d = S_OLD;
      end

      S_OLD: begin
        out_valid_d = 1'b1;
        out_data_d  = rdata;
        out_last_d  = ((CW'(k_q) + CW'(1)) == n_q);
        out_ops_d   = ((CW'(k_q) + CW'(1)) == n_q) ? ops_total : '0;
        state_d     = S_OWAIT;
      end

      S_OWAIT: begin
        // hold the result until the receiver takes the transfer
        if (out_xfer) begin
          out_valid_d = 1'b0;
          if (out_last_q) begin
            state_d = S_IDLE;
          end else begin
            k_d     = k_q + AW'(1);
            state_d = S_ORD;
          end
        end
      end

      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      cnt_q       <= '0;
      n_q         <= '0;
      i_q         <= '0;
      j_q         <= '0;
      k_q         <= '0;
      lvl_q       <= '0;
      gap_q       <= GapW'(1);
      cmp_q       <= '0;
      mov_q       <= '0;
      mode_q      <= GAP_MODE_2K;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      cnt_q       <= cnt_d;
      n_q         <= n_d;
      i_q         <= i_d;
      j_q         <= j_d;
      k_q         <= k_d;
      lvl_q       <= lvl_d;
      gap_q       <= gap_d;
      cmp_q       <= cmp_d;
      mov_q       <= mov_d;
      out_valid_q <= out_valid_d;
      if (cfg_valid_i && cfg_ready_o) begin
        mode_q <= cfg_data_i;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    held_q     <= held_d;
    out_data_q <= out_data_d;
    out_last_q <= out_last_d;
    out_ops_q  <= out_ops_d;
  end

  // items are taken only while collecting a set
  assign in_stall_o     = (state_q != S_IDLE);
  assign cfg_ready_o    = 1'b1;
  assign out_valid_o    = out_valid_q;
  assign sorted_value_o = out_data_q;
  assign last_out_o     = out_last_q;
  assign op_count_o     = out_ops_q;

`ifndef NO_ASSERTIONS
  // no result may be pending while a new set is being collected
  a_idle_no_out: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !in_stall_o |-> !out_valid_o)
    else $error("result pending while collecting input");

  // the op count only rides on the final result
  a_ops_on_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && !last_out_o) |-> (op_count_o == '0))
    else $error("op count on a result that is not last");

  // a transfer marked last closes the set and starts the sort
  a_last_starts: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && !in_stall_o && last_i) |=> in_stall_o)
    else $error("sort did not start after last item");
`endif

endmodule

`default_nettype wire

>>> hdl/ssoc_mem.sv
// element store: one write port, one read port with registered read data
// depends on ssoc_pkg for default sizes
`default_nettype none

module ssoc_mem
  import ssoc_pkg::*;
#(
  parameter int unsigned DEPTH = MaxItemsDef,
  parameter int unsigned DW    = DataWidthDef,
  parameter int unsigned AW    = $clog2(MaxItemsDef)
) (
  input  wire logic          clk_i,
  input  wire logic          we_i,
  input  wire logic [AW-1:0] waddr_i,
  input  wire logic [DW-1:0] wdata_i,
  input  wire logic [AW-1:0] raddr_i,
  output logic      [DW-1:0] rdata_o
);

  logic [DW-1:0] store_q [DEPTH];
  logic [DW-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      store_q[waddr_i] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    rdata_q <= store_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

`default_nettype wire
